// File: rtl/zbh_pkg.sv
`timescale 1ns / 1ps

package zbh_pkg;

   localparam int WORD_W       = 64;
   localparam int KEY_W        = 64;
   localparam int MODE_W       = 2;
   localparam int KEY_INDEX_W  = 9;
   localparam int WORD_INDEX_W = 2;
   localparam int ORBITAL_W    = 7;
   localparam int WPS_W        = 2;
   localparam int BIT_W        = $clog2(WORD_W);
   // word base of a table address: up to 2*3 + 3
   localparam int BASE_W       = 4;
   localparam int RAW_MIN_W    = BASE_W + BIT_W;

   localparam int DEF_MAX_WORDS_PER_SPIN = 2;
   localparam int KEYS_PER_SPIN_WORD     = 256;

   localparam logic [WPS_W-1:0] WPS_RESET = WPS_W'(1);

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_HASH   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_EXCITE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_HASH,
      OP_EXCITE
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH,
      ST_EXC_LO,
      ST_EXC_HI,
      ST_EXC_OUT
   } back_state_type;

   typedef struct packed {
      op_type                  op;
      logic                    last;
      logic [WORD_INDEX_W-1:0] word_index;
      logic                    spin_up;
      logic [WPS_W-1:0]        wps;
      logic [KEY_INDEX_W-1:0]  key_index;
      logic [ORBITAL_W-1:0]    orb_from;
      logic [ORBITAL_W-1:0]    orb_to;
      logic [WORD_W-1:0]       data_a;
      logic [WORD_W-1:0]       data_b;
   } cmd_type;

endpackage

// File: rtl/zbh_if.sv
`timescale 1ns / 1ps

interface zbh_req_if;
   import zbh_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [MODE_W-1:0]       mode;
   logic [KEY_INDEX_W-1:0]  key_index;
   logic [KEY_W-1:0]        key_value;
   logic [WORD_INDEX_W-1:0] word_index;
   logic [WORD_W-1:0]       word_bits;
   logic                    last_word;
   logic [WORD_W-1:0]       ref_hash_first;
   logic [WORD_W-1:0]       ref_hash_second;
   logic [ORBITAL_W-1:0]    orbital_from;
   logic [ORBITAL_W-1:0]    orbital_to;
   logic                    spin_up;

   modport source (
      output valid, mode, key_index, key_value, word_index, word_bits, last_word,
             ref_hash_first, ref_hash_second, orbital_from, orbital_to, spin_up,
      input  ready
   );
   modport sink (
      input  valid, mode, key_index, key_value, word_index, word_bits, last_word,
             ref_hash_first, ref_hash_second, orbital_from, orbital_to, spin_up,
      output ready
   );
endinterface

interface zbh_rsp_if;
   import zbh_pkg::*;

   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] hash_first;
   logic [WORD_W-1:0] hash_second;

   modport source (output valid, hash_first, hash_second, input ready);
   modport sink (input valid, hash_first, hash_second, output ready);
endinterface

interface zbh_csr_if;
   import zbh_pkg::*;

   logic             valid;
   logic             ready;
   logic [WPS_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// File: rtl/zbh_front.sv
`timescale 1ns / 1ps

module zbh_front #(
   parameter int MAX_WORDS_PER_SPIN = zbh_pkg::DEF_MAX_WORDS_PER_SPIN
) (
   input  logic             clock,
   input  logic             reset,
   zbh_req_if.sink          req_port,
   zbh_csr_if.sink          csr_port,
   output zbh_pkg::cmd_type push_data,
   output logic             push_valid,
   input  logic             push_ready
);
   import zbh_pkg::*;

   logic [WPS_W-1:0] csr_ff;
   logic [WPS_W-1:0] csr_in;
   logic [WPS_W-1:0] wps;

   assign csr_port.ready = 1'b1;

   always_comb begin
      csr_in = csr_ff;
      if (csr_port.valid) begin
         csr_in = csr_port.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= WPS_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // register is saturated into the supported range when used
   always_comb begin
      wps = csr_ff;
      if (csr_ff == '0) begin
         wps = WPS_W'(1);
      end else if (int'(csr_ff) > MAX_WORDS_PER_SPIN) begin
         wps = WPS_W'(MAX_WORDS_PER_SPIN);
      end
   end

   // unused mode is taken and dropped here
   assign req_port.ready = push_ready;
   assign push_valid     = req_port.valid && (req_port.mode != MODE_UNUSED);

   always_comb begin
      push_data            = '0;
      push_data.last       = req_port.last_word;
      push_data.word_index = req_port.word_index;
      push_data.spin_up    = req_port.spin_up;
      push_data.wps        = wps;
      push_data.key_index  = req_port.key_index;
      push_data.orb_from   = req_port.orbital_from;
      push_data.orb_to     = req_port.orbital_to;
      push_data.data_b     = req_port.ref_hash_second;
      unique case (req_port.mode)
         MODE_LOAD: begin
            push_data.op     = OP_LOAD;
            push_data.data_a = req_port.key_value;
         end
         MODE_HASH: begin
            push_data.op     = OP_HASH;
            push_data.data_a = req_port.word_bits;
         end
         default: begin
            push_data.op     = OP_EXCITE;
            push_data.data_a = req_port.ref_hash_first;
         end
      endcase
   end

endmodule

// File: rtl/zbh_queue.sv
`timescale 1ns / 1ps

module zbh_queue (
   input  logic             clock,
   input  logic             reset,
   input  zbh_pkg::cmd_type push_data,
   input  logic             push_valid,
   output logic             push_ready,
   output zbh_pkg::cmd_type pop_data,
   output logic             pop_valid,
   input  logic             pop_ready
);
   import zbh_pkg::*;

   cmd_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff;
   logic [QUEUE_PTR_W:0]   count_in;
   logic                   push;
   logic                   pop;

   assign push_ready = (count_ff != (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/zbh_back.sv
`timescale 1ns / 1ps

module zbh_back #(
   parameter int MAX_WORDS_PER_SPIN = zbh_pkg::DEF_MAX_WORDS_PER_SPIN
) (
   input  logic             clock,
   input  logic             reset,
   input  zbh_pkg::cmd_type pop_data,
   input  logic             pop_valid,
   output logic             pop_ready,
   zbh_rsp_if.source        rsp_port
);
   import zbh_pkg::*;

   localparam int DEPTH  = KEYS_PER_SPIN_WORD * MAX_WORDS_PER_SPIN;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int RAW_W  = (ADDR_W + 1 > RAW_MIN_W) ? ADDR_W + 1 : RAW_MIN_W;

   // every raw address stays below twice the depth
   function automatic logic [ADDR_W-1:0] wrap_addr(input logic [RAW_W-1:0] raw);
      logic [RAW_W-1:0] adj;
      adj = (raw >= RAW_W'(DEPTH)) ? raw - RAW_W'(DEPTH) : raw;
      return adj[ADDR_W-1:0];
   endfunction

   logic [KEY_W-1:0] key_mem [DEPTH];

   back_state_type    state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [BIT_W-1:0]  bit_ff, bit_in;
   logic              hit_ff, hit_in;
   logic [WORD_W-1:0] acc_first_ff, acc_first_in;
   logic [WORD_W-1:0] acc_second_ff, acc_second_in;
   logic [WORD_W-1:0] exc_first_ff, exc_first_in;
   logic [KEY_W-1:0]  rd_a_ff, rd_b_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_first_ff, rsp_first_in;
   logic [WORD_W-1:0] rsp_second_ff, rsp_second_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic              rd_en;
   logic [ADDR_W-1:0] addr_a, addr_b;
   logic [BASE_W-1:0] base_a, base_b;
   logic [ORBITAL_W-1:0] ofs_a, ofs_b;
   logic [BASE_W-1:0] wps2;
   logic [BASE_W-1:0] exc_lo, exc_hi;
   logic [WORD_W-1:0] acc_first_next, acc_second_next;
   logic              out_free;
   logic              out_load;

   assign wps2   = BASE_W'({cmd_ff.wps, 1'b0});
   assign exc_lo = cmd_ff.spin_up ? '0 : BASE_W'(cmd_ff.wps);
   assign exc_hi = exc_lo + wps2;

   assign acc_first_next  = acc_first_ff ^ (hit_ff ? rd_a_ff : '0);
   assign acc_second_next = acc_second_ff ^ (hit_ff ? rd_b_ff : '0);

   assign out_free  = !rsp_valid_ff || rsp_port.ready;
   assign pop_ready = (state_ff == ST_IDLE);

   assign addr_a = wrap_addr(RAW_W'({base_a, {BIT_W{1'b0}}}) + RAW_W'(ofs_a));
   assign addr_b = wrap_addr(RAW_W'({base_b, {BIT_W{1'b0}}}) + RAW_W'(ofs_b));

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      bit_in        = bit_ff;
      hit_in        = 1'b0;
      acc_first_in  = acc_first_next;
      acc_second_in = acc_second_next;
      exc_first_in  = exc_first_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_second_in = rsp_second_ff;
      out_load      = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = wrap_addr(RAW_W'(pop_data.key_index));
      rd_en         = 1'b0;
      base_a        = BASE_W'(cmd_ff.word_index);
      base_b        = wps2 + BASE_W'(cmd_ff.word_index);
      ofs_a         = ORBITAL_W'(bit_ff);
      ofs_b         = ORBITAL_W'(bit_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               cmd_in = pop_data;
               bit_in = '0;
               unique case (pop_data.op)
                  OP_LOAD:   wr_en    = 1'b1;
                  OP_HASH:   state_in = ST_SCAN;
                  default:   state_in = ST_EXC_LO;
               endcase
            end
         end
         ST_SCAN: begin
            rd_en  = cmd_ff.data_a[bit_ff];
            hit_in = cmd_ff.data_a[bit_ff];
            bit_in = bit_ff + 1'b1;
            if (bit_ff == BIT_W'(WORD_W - 1)) begin
               state_in = cmd_ff.last ? ST_FINISH : ST_IDLE;
            end
         end
         ST_FINISH: begin
            // the last bit's keys land here; a stall just holds the sum
            if (out_free) begin
               out_load      = 1'b1;
               rsp_first_in  = acc_first_next;
               rsp_second_in = acc_second_next;
               acc_first_in  = '0;
               acc_second_in = '0;
               state_in      = ST_IDLE;
            end
         end
         ST_EXC_LO: begin
            rd_en    = 1'b1;
            base_a   = exc_lo;
            base_b   = exc_lo;
            ofs_a    = cmd_ff.orb_from;
            ofs_b    = cmd_ff.orb_to;
            state_in = ST_EXC_HI;
         end
         ST_EXC_HI: begin
            rd_en        = 1'b1;
            base_a       = exc_hi;
            base_b       = exc_hi;
            ofs_a        = cmd_ff.orb_from;
            ofs_b        = cmd_ff.orb_to;
            exc_first_in = cmd_ff.data_a ^ rd_a_ff ^ rd_b_ff;
            state_in     = ST_EXC_OUT;
         end
         ST_EXC_OUT: begin
            if (out_free) begin
               out_load      = 1'b1;
               rsp_first_in  = exc_first_ff;
               rsp_second_in = cmd_ff.data_b ^ rd_a_ff ^ rd_b_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         bit_ff        <= '0;
         hit_ff        <= 1'b0;
         acc_first_ff  <= '0;
         acc_second_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         bit_ff        <= bit_in;
         hit_ff        <= hit_in;
         acc_first_ff  <= acc_first_in;
         acc_second_ff <= acc_second_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      exc_first_ff  <= exc_first_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
   end

   // key table: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= pop_data.data_a;
      end
      if (rd_en) begin
         rd_a_ff <= key_mem[addr_a];
         rd_b_ff <= key_mem[addr_b];
      end
   end

   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.hash_first  = rsp_first_ff;
   assign rsp_port.hash_second = rsp_second_ff;

endmodule

// File: rtl/dual_zobrist_bitstring_hash.sv
`timescale 1ns / 1ps

// channel    dir   handshake       word
// req_port   in    valid/ready     mode, key, hash word or excitation operands
// rsp_port   out   valid/ready     hash_first, hash_second
// csr_port   in    valid/ready     words_per_spin (always ready)
//
// Back end: a load word is written when popped; a hash word is popped, then
// scanned one bit a cycle on the table's two read ports, plus a finish state
// for the last word; excitation: pop, two rounds of two table reads, result.
// A 2-word queue splits intake from execution; the result register lets the
// next word start while a result waits. Reset is synchronous; the key table
// is not cleared and holds garbage until loaded.

module dual_zobrist_bitstring_hash #(
   parameter int MAX_WORDS_PER_SPIN = zbh_pkg::DEF_MAX_WORDS_PER_SPIN
) (
   input logic       clock,
   input logic       reset,
   zbh_req_if.sink   req_port,
   zbh_csr_if.sink   csr_port,
   zbh_rsp_if.source rsp_port
);
   import zbh_pkg::*;

   cmd_type push_data;
   logic    push_valid;
   logic    push_ready;
   cmd_type pop_data;
   logic    pop_valid;
   logic    pop_ready;

   zbh_front #(
      .MAX_WORDS_PER_SPIN(MAX_WORDS_PER_SPIN)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_port   (req_port),
      .csr_port   (csr_port),
      .push_data  (push_data),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   zbh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_data  (push_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_data   (pop_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready)
   );

   zbh_back #(
      .MAX_WORDS_PER_SPIN(MAX_WORDS_PER_SPIN)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_data  (pop_data),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .rsp_port  (rsp_port)
   );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import zbh_pkg::*;

   localparam int KEY_DEPTH    = KEYS_PER_SPIN_WORD * DEF_MAX_WORDS_PER_SPIN;
   localparam int DRAIN_CYCLES = 300;
   localparam int CYCLE_LIMIT  = 1_000_000;

   typedef struct {
      logic [MODE_W-1:0]       mode;
      logic [KEY_INDEX_W-1:0]  key_index;
      logic [KEY_W-1:0]        key_value;
      logic [WORD_INDEX_W-1:0] word_index;
      logic [WORD_W-1:0]       word_bits;
      logic                    last_word;
      logic [WORD_W-1:0]       ref_hash_first;
      logic [WORD_W-1:0]       ref_hash_second;
      logic [ORBITAL_W-1:0]    orbital_from;
      logic [ORBITAL_W-1:0]    orbital_to;
      logic                    spin_up;
   } zbh_word_type;

   typedef struct {
      logic [WORD_W-1:0] first;
      logic [WORD_W-1:0] second;
   } hash_pair_type;

   logic clock;
   logic reset;

   zbh_req_if req_bus ();
   zbh_rsp_if rsp_bus ();
   zbh_csr_if csr_bus ();

   dual_zobrist_bitstring_hash u_top (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .csr_port (csr_bus),
      .rsp_port (rsp_bus)
   );

   // shadow of the block state
   logic [KEY_W-1:0]  key_mirror [KEY_DEPTH];
   logic [WPS_W-1:0]  wps_reg = WPS_RESET;
   logic [WORD_W-1:0] acc_first_model = '0;
   logic [WORD_W-1:0] acc_second_model = '0;
   hash_pair_type     pending_hashes [$];

   int error_count = 0;
   int cycle_count = 0;
   int rsp_stall_left = 0;
   int rsp_taken = 0;
   int rsp_seen = 0;
   bit idle_en = 1'b0;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d hash pairs outstanding", $time, pending_hashes.size());
         $display("[dual_zobrist_bitstring_hash] ERROR");
         $finish;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // mix of dense, sparse and extreme occupations
   function automatic logic [WORD_W-1:0] hash_bits();
      unique case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return 64'd1 << $urandom_range(0, 63);
         3: return rand64() & rand64() & rand64();
         default: return rand64();
      endcase
   endfunction

   function automatic zbh_word_type noise_word(logic [MODE_W-1:0] mode);
      zbh_word_type w;
      w.mode            = mode;
      w.key_index       = KEY_INDEX_W'($urandom);
      w.key_value       = rand64();
      w.word_index      = WORD_INDEX_W'($urandom);
      w.word_bits       = rand64();
      w.last_word       = 1'($urandom);
      w.ref_hash_first  = rand64();
      w.ref_hash_second = rand64();
      w.orbital_from    = ORBITAL_W'($urandom);
      w.orbital_to      = ORBITAL_W'($urandom);
      w.spin_up         = 1'($urandom);
      return w;
   endfunction

   function automatic void predict_word(zbh_word_type w);
      int            wps;
      int            half;
      int            off;
      int            base1;
      int            base2;
      int            b;
      hash_pair_type p;
      wps = (wps_reg < 1) ? 1 :
            ((wps_reg > DEF_MAX_WORDS_PER_SPIN) ? DEF_MAX_WORDS_PER_SPIN : int'(wps_reg));
      half = 2 * wps;
      unique case (w.mode)
         MODE_LOAD: key_mirror[int'(w.key_index) % KEY_DEPTH] = w.key_value;
         MODE_HASH: begin
            for (b = 0; b < WORD_W; b++) begin
               if (w.word_bits[b]) begin
                  acc_first_model ^=
                     key_mirror[(int'(w.word_index) * WORD_W + b) % KEY_DEPTH];
                  acc_second_model ^=
                     key_mirror[((half + int'(w.word_index)) * WORD_W + b) % KEY_DEPTH];
               end
            end
            if (w.last_word) begin
               p.first  = acc_first_model;
               p.second = acc_second_model;
               pending_hashes.push_back(p);
               acc_first_model  = '0;
               acc_second_model = '0;
            end
         end
         MODE_EXCITE: begin
            off   = w.spin_up ? 0 : wps;
            base1 = off * WORD_W;
            base2 = (off + half) * WORD_W;
            p.first  = w.ref_hash_first
                     ^ key_mirror[(base1 + int'(w.orbital_from)) % KEY_DEPTH]
                     ^ key_mirror[(base1 + int'(w.orbital_to)) % KEY_DEPTH];
            p.second = w.ref_hash_second
                     ^ key_mirror[(base2 + int'(w.orbital_from)) % KEY_DEPTH]
                     ^ key_mirror[(base2 + int'(w.orbital_to)) % KEY_DEPTH];
            pending_hashes.push_back(p);
         end
         default: ;
      endcase
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_word(input zbh_word_type w);
      int gap;
      gap = idle_en ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.mode            = w.mode;
      req_bus.key_index       = w.key_index;
      req_bus.key_value       = w.key_value;
      req_bus.word_index      = w.word_index;
      req_bus.word_bits       = w.word_bits;
      req_bus.last_word       = w.last_word;
      req_bus.ref_hash_first  = w.ref_hash_first;
      req_bus.ref_hash_second = w.ref_hash_second;
      req_bus.orbital_from    = w.orbital_from;
      req_bus.orbital_to      = w.orbital_to;
      req_bus.spin_up         = w.spin_up;
      req_bus.valid           = 1'b1;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predict_word(w);
      @(negedge clock);
   endtask

   // loads and dropped words give no result, so allow the back end to finish
   task automatic wait_idle();
      req_bus.valid = 1'b0;
      while (pending_hashes.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_wps(input logic [WPS_W-1:0] value);
      wait_idle();
      csr_bus.data  = value;
      csr_bus.valid = 1'b1;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      wps_reg = value;
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task automatic send_hash_string(input int n_words);
      zbh_word_type w;
      int           k;
      for (k = 0; k < n_words; k++) begin
         w            = noise_word(MODE_HASH);
         w.word_index = WORD_INDEX_W'(k);
         w.word_bits  = hash_bits();
         w.last_word  = (k == n_words - 1);
         send_word(w);
      end
   endtask

   task automatic random_mix(input int n_items);
      zbh_word_type w;
      int           sent;
      int           pick;
      int           n;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            n = $urandom_range(1, 4);
            send_hash_string(n);
            sent += n;
         end else begin
            if (pick < 80) begin
               w = noise_word(MODE_EXCITE);
            end else if (pick < 88) begin
               w = noise_word(MODE_LOAD);
            end else if (pick < 93) begin
               w = noise_word(MODE_UNUSED);
            end else begin
               // stray partial word: folds into whatever string comes next
               w = noise_word(MODE_HASH);
               w.word_bits = hash_bits();
               w.last_word = 1'b0;
            end
            send_word(w);
            sent++;
         end
      end
   endtask

   task automatic test_key_load();
      zbh_word_type w;
      int           i;
      idle_en = 1'b1;
      for (i = 0; i < KEY_DEPTH; i++) begin
         w           = noise_word(MODE_LOAD);
         w.key_index = KEY_INDEX_W'(i);
         if (i == 0)      w.key_value = '1;
         else if (i == 1) w.key_value = '0;
         send_word(w);
      end
   endtask

   task automatic test_directed();
      zbh_word_type w;
      idle_en = 1'b0;

      w = noise_word(MODE_HASH);
      w.word_index = 2'd0; w.word_bits = '0; w.last_word = 1'b1;
      send_word(w);
      w = noise_word(MODE_HASH);
      w.word_index = 2'd3; w.word_bits = '1; w.last_word = 1'b1;
      send_word(w);

      // four-word string, top bit only, low bit only, full, random
      w = noise_word(MODE_HASH);
      w.word_index = 2'd0; w.word_bits = 64'h8000_0000_0000_0000; w.last_word = 1'b0;
      send_word(w);
      w.word_index = 2'd1; w.word_bits = 64'd1;
      send_word(w);
      w.word_index = 2'd2; w.word_bits = '1;
      send_word(w);
      w.word_index = 2'd3; w.word_bits = rand64(); w.last_word = 1'b1;
      send_word(w);

      w = noise_word(MODE_EXCITE);
      w.spin_up = 1'b1; w.orbital_from = 7'd0; w.orbital_to = 7'd127;
      w.ref_hash_first = '0; w.ref_hash_second = '0;
      send_word(w);
      w = noise_word(MODE_EXCITE);
      w.spin_up = 1'b0; w.orbital_from = 7'd127; w.orbital_to = 7'd0;
      w.ref_hash_first = '1; w.ref_hash_second = '1;
      send_word(w);
      // same orbital twice cancels
      w = noise_word(MODE_EXCITE);
      w.orbital_to = w.orbital_from;
      send_word(w);

      send_word(noise_word(MODE_UNUSED));
      send_word(noise_word(MODE_UNUSED));

      w = noise_word(MODE_LOAD);
      w.key_index = 9'd511; w.key_value = '1;
      send_word(w);
      w = noise_word(MODE_LOAD);
      w.key_index = 9'd0; w.key_value = 64'h0123_4567_89ab_cdef;
      send_word(w);
      w = noise_word(MODE_HASH);
      w.word_index = 2'd0; w.word_bits = 64'd1; w.last_word = 1'b1;
      send_word(w);

      // non-final word then a final one with nothing set
      w = noise_word(MODE_HASH);
      w.word_index = 2'd1; w.last_word = 1'b0;
      send_word(w);
      w = noise_word(MODE_HASH);
      w.word_index = 2'd2; w.word_bits = '0; w.last_word = 1'b1;
      send_word(w);
   endtask

   // corners that move with the spin offset
   task automatic w_directed_corners();
      zbh_word_type w;
      w = noise_word(MODE_EXCITE);
      w.spin_up = 1'b0; w.orbital_from = 7'd127; w.orbital_to = 7'd127;
      send_word(w);
      w = noise_word(MODE_HASH);
      w.word_index = 2'd3; w.word_bits = '1; w.last_word = 1'b1;
      send_word(w);
   endtask

   task automatic test_register_settings();
      logic [WPS_W-1:0] settings [4] = '{2'd0, 2'd3, 2'd2, 2'd1};
      int               s;
      for (s = 0; s < 4; s++) begin
         write_wps(settings[s]);
         idle_en = settings[s][0];
         w_directed_corners();
         random_mix(36);
      end
   endtask

   task automatic test_random_traffic();
      int phase;
      for (phase = 0; phase < 10; phase++) begin
         write_wps(WPS_W'($urandom_range(0, 3)));
         idle_en = (phase % 3) != 0;
         if (phase == 4) begin
            random_mix(55);
            wait_idle();
            random_mix(55);
         end else begin
            random_mix(110);
         end
      end
   endtask

   // a new stall is drawn after each taken hash pair
   always @(negedge clock) begin
      if (rsp_taken != rsp_seen) begin
         rsp_seen       = rsp_taken;
         rsp_stall_left = idle_en ? $urandom_range(0, 4) : 0;
      end
      if (rsp_stall_left > 0) begin
         rsp_bus.ready = 1'b0;
         rsp_stall_left--;
      end else begin
         rsp_bus.ready = 1'b1;
      end
   end

   always @(posedge clock) begin : check_hashes
      hash_pair_type exp_pair;
      if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_hashes.size() == 0) begin
            error_count++;
            $display("%0t: hash pair with none expected: %h %h", $time,
                     rsp_bus.hash_first, rsp_bus.hash_second);
         end else begin
            exp_pair = pending_hashes.pop_front();
            if (rsp_bus.hash_first !== exp_pair.first) begin
               error_count++;
               $display("%0t: hash_first expected %h actual %h", $time,
                        exp_pair.first, rsp_bus.hash_first);
            end
            if (rsp_bus.hash_second !== exp_pair.second) begin
               error_count++;
               $display("%0t: hash_second expected %h actual %h", $time,
                        exp_pair.second, rsp_bus.hash_second);
            end
         end
         rsp_taken++;
      end
   end

   initial begin
      reset                   = 1'b1;
      req_bus.valid           = 1'b0;
      req_bus.mode            = MODE_LOAD;
      req_bus.key_index       = '0;
      req_bus.key_value       = '0;
      req_bus.word_index      = '0;
      req_bus.word_bits       = '0;
      req_bus.last_word       = 1'b0;
      req_bus.ref_hash_first  = '0;
      req_bus.ref_hash_second = '0;
      req_bus.orbital_from    = '0;
      req_bus.orbital_to      = '0;
      req_bus.spin_up         = 1'b0;
      csr_bus.valid           = 1'b0;
      csr_bus.data            = WPS_RESET;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_key_load();
      test_directed();
      test_register_settings();
      test_random_traffic();
      wait_idle();

      if (error_count == 0) begin
         $display("[dual_zobrist_bitstring_hash] OK");
      end else begin
         $display("[dual_zobrist_bitstring_hash] ERROR");
      end
      $finish;
   end

endmodule
